[rtl/core/npss_pkg.sv]
// Shared types and constants for the nearest point on segment set block.
package npss_pkg;

   // Coordinate and arithmetic widths.
   localparam int COORD_W  = 32;
   localparam int D_W      = COORD_W + 1;
   localparam int M_W      = COORD_W + 2;
   localparam int P_W      = 2 * M_W;
   localparam int TFRAC    = 32;
   localparam int STEP_W   = 5;
   localparam int SQ_W     = 64;
   localparam int SQ_TOP   = 62;
   localparam int DIST_W   = 31;
   localparam int SEGIDX_W = 6;
   localparam int CNT_REG_W = 7;

   // Opcodes of an input transaction.
   localparam logic OPC_LOAD  = 1'b0;
   localparam logic OPC_QUERY = 1'b1;

   typedef struct packed {
      logic                        opcode;
      logic [SEGIDX_W-1:0]         seg_index;
      logic signed [COORD_W-1:0]   start_x;
      logic signed [COORD_W-1:0]   start_y;
      logic signed [COORD_W-1:0]   end_x;
      logic signed [COORD_W-1:0]   end_y;
      logic signed [COORD_W-1:0]   point_x;
      logic signed [COORD_W-1:0]   point_y;
   } req_type;

   typedef struct packed {
      logic                        found;
      logic [DIST_W-1:0]           distance;
      logic signed [COORD_W-1:0]   closest_x;
      logic signed [COORD_W-1:0]   closest_y;
      logic [SEGIDX_W-1:0]         nearest_index;
   } rsp_type;

   // One stored segment.
   typedef struct packed {
      logic signed [COORD_W-1:0]   ax;
      logic signed [COORD_W-1:0]   ay;
      logic signed [COORD_W-1:0]   bx;
      logic signed [COORD_W-1:0]   by;
   } seg_entry_type;

   // Datapath operations issued by the controller.
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_START,
      OP_READ,
      OP_DIFF,
      OP_MUL_UU,
      OP_MUL_VV,
      OP_MUL_WU,
      OP_MUL_WV,
      OP_NUM_SUM,
      OP_SEL_A,
      OP_SEL_B,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_MUL_IX,
      OP_MUL_IY,
      OP_INTERP_Y,
      OP_DIST,
      OP_MUL_DX,
      OP_MUL_DY,
      OP_DIST_SUM,
      OP_COMPARE,
      OP_SQRT_INIT,
      OP_SQRT_STEP,
      OP_RESULT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic degenerate;
      logic num_le0;
      logic num_ge_den;
      logic found;
   } dp_status_type;

endpackage

[rtl/core/npss_datapath.sv]
// Datapath: segment memory, shared multiplier, divider, compare and square root.
module npss_datapath import npss_pkg::*; #(
   parameter int MAX_SEGMENTS = 64
) (
   input  logic          clock,
   input  req_type       req_data,
   input  dp_cmd_type    dp_cmd,
   input  logic [((MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1)-1:0] seg_addr,
   output dp_status_type dp_status,
   output rsp_type       rsp_data
);

   localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam logic signed [P_W-1:0] ROUND_HALF = P_W'(64'd1 << (TFRAC - 1));
   localparam logic [SQ_W-1:0] SQ_FIRST_BIT = SQ_W'(64'd1 << SQ_TOP);

   seg_entry_type seg_mem [MAX_SEGMENTS];
   seg_entry_type seg_ff;

   logic signed [COORD_W-1:0] pt_x_ff, pt_y_ff;
   logic signed [D_W-1:0]     ux_ff, uy_ff, wx_ff, wy_ff, dx_ff, dy_ff;
   logic signed [P_W-1:0]     p_ff, den_ff, num_ff, s_ff, best_ff;
   logic [P_W-1:0]            rem_ff;
   logic [TFRAC-1:0]          t_ff;
   logic signed [COORD_W-1:0] cx_ff, cy_ff, best_x_ff, best_y_ff;
   logic [IDX_W-1:0]          best_idx_ff;
   logic                      found_ff, sat_ff;
   logic [SQ_W-1:0]           sq_v_ff, sq_res_ff, sq_bit_ff;
   rsp_type                   rsp_ff;

   logic signed [M_W-1:0]     mul_a, mul_b;
   logic [D_W-1:0]            ux_mag, uy_mag;
   logic [P_W-1:0]            rem_sh;
   logic signed [P_W-1:0]     rnd;
   logic [M_W-1:0]            interp_v;
   logic signed [M_W-1:0]     interp_res;
   logic [SQ_W-1:0]           sq_sum;
   logic                      wr_ok;
   logic [IDX_W-1:0]          wr_addr;

   // Magnitudes of the direction vector for interpolation.
   assign ux_mag = ux_ff[D_W-1] ? D_W'(-ux_ff) : D_W'(ux_ff);
   assign uy_mag = uy_ff[D_W-1] ? D_W'(-uy_ff) : D_W'(uy_ff);

   // Load address check and truncation to the memory depth.
   assign wr_ok   = (32'(req_data.seg_index) < 32'(MAX_SEGMENTS));
   assign wr_addr = IDX_W'(req_data.seg_index);

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (dp_cmd.op)
         OP_MUL_UU: begin
            mul_a = {ux_ff[D_W-1], ux_ff};
            mul_b = {ux_ff[D_W-1], ux_ff};
         end
         OP_MUL_VV: begin
            mul_a = {uy_ff[D_W-1], uy_ff};
            mul_b = {uy_ff[D_W-1], uy_ff};
         end
         OP_MUL_WU: begin
            mul_a = {wx_ff[D_W-1], wx_ff};
            mul_b = {ux_ff[D_W-1], ux_ff};
         end
         OP_MUL_WV: begin
            mul_a = {wy_ff[D_W-1], wy_ff};
            mul_b = {uy_ff[D_W-1], uy_ff};
         end
         OP_MUL_IX: begin
            mul_a = {1'b0, ux_mag};
            mul_b = {2'b00, t_ff};
         end
         OP_MUL_IY: begin
            mul_a = {1'b0, uy_mag};
            mul_b = {2'b00, t_ff};
         end
         OP_MUL_DX: begin
            mul_a = {dx_ff[D_W-1], dx_ff};
            mul_b = {dx_ff[D_W-1], dx_ff};
         end
         OP_MUL_DY: begin
            mul_a = {dy_ff[D_W-1], dy_ff};
            mul_b = {dy_ff[D_W-1], dy_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Rounded interpolation offset from the previous product.
   always_comb begin
      rnd      = p_ff + ROUND_HALF;
      interp_v = rnd[TFRAC+M_W-1:TFRAC];
      if (dp_cmd.op == OP_MUL_IY) begin
         interp_res = ux_ff[D_W-1] ? ({{2{seg_ff.ax[COORD_W-1]}}, seg_ff.ax} - interp_v)
                                   : ({{2{seg_ff.ax[COORD_W-1]}}, seg_ff.ax} + interp_v);
      end else begin
         interp_res = uy_ff[D_W-1] ? ({{2{seg_ff.ay[COORD_W-1]}}, seg_ff.ay} - interp_v)
                                   : ({{2{seg_ff.ay[COORD_W-1]}}, seg_ff.ay} + interp_v);
      end
   end

   assign rem_sh = {rem_ff[P_W-2:0], 1'b0};
   assign sq_sum = sq_res_ff + sq_bit_ff;

   // Segment memory: one write port for loads, one registered read port.
   always_ff @(posedge clock) begin
      if (dp_cmd.op == OP_LOAD && wr_ok) begin
         seg_mem[wr_addr] <= '{ax: req_data.start_x, ay: req_data.start_y,
                                bx: req_data.end_x,   by: req_data.end_y};
      end
      if (dp_cmd.op == OP_READ) begin
         seg_ff <= seg_mem[seg_addr];
      end
   end

   // Arithmetic registers, advanced one operation per cycle.
   always_ff @(posedge clock) begin
      unique case (dp_cmd.op)
         OP_START: begin
            pt_x_ff  <= req_data.point_x;
            pt_y_ff  <= req_data.point_y;
            found_ff <= 1'b0;
         end
         OP_DIFF: begin
            ux_ff <= {seg_ff.bx[COORD_W-1], seg_ff.bx} - {seg_ff.ax[COORD_W-1], seg_ff.ax};
            uy_ff <= {seg_ff.by[COORD_W-1], seg_ff.by} - {seg_ff.ay[COORD_W-1], seg_ff.ay};
            wx_ff <= {pt_x_ff[COORD_W-1], pt_x_ff} - {seg_ff.ax[COORD_W-1], seg_ff.ax};
            wy_ff <= {pt_y_ff[COORD_W-1], pt_y_ff} - {seg_ff.ay[COORD_W-1], seg_ff.ay};
         end
         OP_MUL_UU: p_ff <= mul_a * mul_b;
         OP_MUL_VV: begin
            p_ff   <= mul_a * mul_b;
            den_ff <= p_ff;
         end
         OP_MUL_WU: begin
            p_ff   <= mul_a * mul_b;
            den_ff <= den_ff + p_ff;
         end
         OP_MUL_WV: begin
            p_ff   <= mul_a * mul_b;
            num_ff <= p_ff;
         end
         OP_NUM_SUM: num_ff <= num_ff + p_ff;
         OP_SEL_A: begin
            cx_ff <= seg_ff.ax;
            cy_ff <= seg_ff.ay;
         end
         OP_SEL_B: begin
            cx_ff <= seg_ff.bx;
            cy_ff <= seg_ff.by;
         end
         OP_DIV_INIT: begin
            rem_ff <= num_ff;
            t_ff   <= '0;
         end
         OP_DIV_STEP: begin
            if (rem_sh >= $unsigned(den_ff)) begin
               rem_ff <= rem_sh - $unsigned(den_ff);
               t_ff   <= {t_ff[TFRAC-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               t_ff   <= {t_ff[TFRAC-2:0], 1'b0};
            end
         end
         OP_MUL_IX: p_ff <= mul_a * mul_b;
         OP_MUL_IY: begin
            p_ff  <= mul_a * mul_b;
            cx_ff <= COORD_W'(interp_res);
         end
         OP_INTERP_Y: cy_ff <= COORD_W'(interp_res);
         OP_DIST: begin
            dx_ff <= {pt_x_ff[COORD_W-1], pt_x_ff} - {cx_ff[COORD_W-1], cx_ff};
            dy_ff <= {pt_y_ff[COORD_W-1], pt_y_ff} - {cy_ff[COORD_W-1], cy_ff};
         end
         OP_MUL_DX: p_ff <= mul_a * mul_b;
         OP_MUL_DY: begin
            p_ff <= mul_a * mul_b;
            s_ff <= p_ff;
         end
         OP_DIST_SUM: s_ff <= s_ff + p_ff;
         OP_COMPARE: begin
            // Only a strictly smaller distance replaces the best, so earlier slots win ties.
            if (!found_ff || s_ff < best_ff) begin
               found_ff    <= 1'b1;
               best_ff     <= s_ff;
               best_x_ff   <= cx_ff;
               best_y_ff   <= cy_ff;
               best_idx_ff <= seg_addr;
            end
         end
         OP_SQRT_INIT: begin
            sat_ff    <= (best_ff[P_W-1:SQ_TOP] != '0);
            sq_v_ff   <= {2'b00, best_ff[SQ_TOP-1:0]};
            sq_res_ff <= '0;
            sq_bit_ff <= SQ_FIRST_BIT;
         end
         OP_SQRT_STEP: begin
            if (sq_v_ff >= sq_sum) begin
               sq_v_ff   <= sq_v_ff - sq_sum;
               sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_ff <= sq_res_ff >> 1;
            end
            sq_bit_ff <= sq_bit_ff >> 2;
         end
         OP_RESULT: begin
            if (found_ff) begin
               rsp_ff.found         <= 1'b1;
               rsp_ff.distance      <= sat_ff ? '1 : sq_res_ff[DIST_W-1:0];
               rsp_ff.closest_x     <= best_x_ff;
               rsp_ff.closest_y     <= best_y_ff;
               rsp_ff.nearest_index <= SEGIDX_W'(best_idx_ff);
            end else begin
               rsp_ff <= '0;
            end
         end
         default: begin
         end
      endcase
   end

   // Status back to the controller.
   assign dp_status.degenerate = (ux_ff == '0) && (uy_ff == '0);
   assign dp_status.num_le0    = num_ff[P_W-1] || (num_ff == '0);
   assign dp_status.num_ge_den = (num_ff >= den_ff);
   assign dp_status.found      = found_ff;

   assign rsp_data = rsp_ff;

endmodule

[rtl/core/npss_ctrl.sv]
// Controller: sequences loads, the per-segment walk, square root and result hand-off.
module npss_ctrl import npss_pkg::*; #(
   parameter int MAX_SEGMENTS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_opcode,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 csr_wr_en,
   input  logic [CNT_REG_W-1:0] csr_wr_data,
   input  dp_status_type        dp_status,
   output dp_cmd_type           dp_cmd,
   output logic [((MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1)-1:0] seg_addr
);

   localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

   typedef enum logic [4:0] {
      ST_IDLE, ST_READ, ST_DIFF, ST_MUL_UU, ST_MUL_VV, ST_MUL_WU, ST_MUL_WV,
      ST_NUM_SUM, ST_CLASS, ST_DIV, ST_MUL_IX, ST_MUL_IY, ST_INTERP_Y, ST_DIST,
      ST_MUL_DX, ST_MUL_DY, ST_DIST_SUM, ST_COMPARE, ST_NEXT, ST_SQRT_INIT,
      ST_SQRT, ST_FIN
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     idx_ff, idx_in, n_ff, n_in, limit, idx_nxt;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CNT_REG_W-1:0] count_ff;

   // Segments a query walks: the register, capped at the table depth.
   assign limit = (32'(count_ff) >= 32'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS)
                                                       : CNT_W'(count_ff);
   assign idx_nxt = idx_ff + 1'b1;

   // Next state and datapath command.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      dp_cmd.op    = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == OPC_LOAD) begin
                  dp_cmd.op = OP_LOAD;
               end else begin
                  dp_cmd.op = OP_START;
                  idx_in    = '0;
                  n_in      = limit;
                  state_in  = (limit == '0) ? ST_FIN : ST_READ;
               end
            end
         end
         ST_READ: begin
            dp_cmd.op = OP_READ;
            state_in  = ST_DIFF;
         end
         ST_DIFF: begin
            dp_cmd.op = OP_DIFF;
            state_in  = ST_MUL_UU;
         end
         ST_MUL_UU: begin
            // Zero-length segments are skipped.
            if (dp_status.degenerate) begin
               state_in = ST_NEXT;
            end else begin
               dp_cmd.op = OP_MUL_UU;
               state_in  = ST_MUL_VV;
            end
         end
         ST_MUL_VV: begin
            dp_cmd.op = OP_MUL_VV;
            state_in  = ST_MUL_WU;
         end
         ST_MUL_WU: begin
            dp_cmd.op = OP_MUL_WU;
            state_in  = ST_MUL_WV;
         end
         ST_MUL_WV: begin
            dp_cmd.op = OP_MUL_WV;
            state_in  = ST_NUM_SUM;
         end
         ST_NUM_SUM: begin
            dp_cmd.op = OP_NUM_SUM;
            state_in  = ST_CLASS;
         end
         ST_CLASS: begin
            // Clamp to an endpoint, or divide for the interior fraction.
            priority if (dp_status.num_le0) begin
               dp_cmd.op = OP_SEL_A;
               state_in  = ST_DIST;
            end else if (dp_status.num_ge_den) begin
               dp_cmd.op = OP_SEL_B;
               state_in  = ST_DIST;
            end else begin
               dp_cmd.op = OP_DIV_INIT;
               step_in   = '0;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            dp_cmd.op = OP_DIV_STEP;
            step_in   = step_ff + 1'b1;
            if (step_ff == STEP_W'(TFRAC - 1)) begin
               state_in = ST_MUL_IX;
            end
         end
         ST_MUL_IX: begin
            dp_cmd.op = OP_MUL_IX;
            state_in  = ST_MUL_IY;
         end
         ST_MUL_IY: begin
            dp_cmd.op = OP_MUL_IY;
            state_in  = ST_INTERP_Y;
         end
         ST_INTERP_Y: begin
            dp_cmd.op = OP_INTERP_Y;
            state_in  = ST_DIST;
         end
         ST_DIST: begin
            dp_cmd.op = OP_DIST;
            state_in  = ST_MUL_DX;
         end
         ST_MUL_DX: begin
            dp_cmd.op = OP_MUL_DX;
            state_in  = ST_MUL_DY;
         end
         ST_MUL_DY: begin
            dp_cmd.op = OP_MUL_DY;
            state_in  = ST_DIST_SUM;
         end
         ST_DIST_SUM: begin
            dp_cmd.op = OP_DIST_SUM;
            state_in  = ST_COMPARE;
         end
         ST_COMPARE: begin
            dp_cmd.op = OP_COMPARE;
            state_in  = ST_NEXT;
         end
         ST_NEXT: begin
            idx_in = idx_nxt;
            if (idx_nxt == n_ff) begin
               state_in = dp_status.found ? ST_SQRT_INIT : ST_FIN;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_SQRT_INIT: begin
            dp_cmd.op = OP_SQRT_INIT;
            step_in   = '0;
            state_in  = ST_SQRT;
         end
         ST_SQRT: begin
            dp_cmd.op = OP_SQRT_STEP;
            step_in   = step_ff + 1'b1;
            if (step_ff == STEP_W'(SQ_W / 2 - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // Load the output register once it is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               dp_cmd.op    = OP_RESULT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State, counters, result valid and the segment count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         n_ff         <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         n_ff         <= n_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign seg_addr  = idx_ff[IDX_W-1:0];

endmodule

[rtl/core/nearest_point_on_segment_set.sv]
// Top level of the nearest point on segment set block.
//
// Usage: the request channel (req_valid, req_stall, req_data) carries load and
// query transactions. A load writes one segment into the table and gives no
// result; a slot at or beyond MAX_SEGMENTS is ignored. A query walks
// segments 0 to min(segment_count, MAX_SEGMENTS) - 1 and gives one transaction
// on the result channel (rsp_valid, rsp_stall, rsp_data).
// The segment count is written through csr_wr_en / csr_wr_data while idle; the
// block itself does not enforce this. Each segment is clamped to an endpoint,
// or the 32-step restoring divider runs for the interior fraction; a segment
// of zero length is skipped. The query then runs the bit-pair square root
// (skipped when nothing is found) and loads the output register. The one
// shared multiplier and the divider are used in turn; one query is in flight
// at a time and req_stall is high while it runs.
// A finished result waits in the output register while rsp_stall is high, and
// a new request is taken meanwhile; a further result waits for that register.
// Reset clears the controller and the segment count; table contents are
// undefined until loaded.
module nearest_point_on_segment_set import npss_pkg::*; #(
   parameter int MAX_SEGMENTS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_wr_en,
   input  logic [CNT_REG_W-1:0] csr_wr_data
);

   localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

   dp_cmd_type       dp_cmd;
   dp_status_type    dp_status;
   logic [IDX_W-1:0] seg_addr;

   npss_ctrl #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .dp_status  (dp_status),
      .dp_cmd     (dp_cmd),
      .seg_addr   (seg_addr)
   );

   npss_datapath #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_datapath (
      .clock    (clock),
      .req_data (req_data),
      .dp_cmd   (dp_cmd),
      .seg_addr (seg_addr),
      .dp_status(dp_status),
      .rsp_data (rsp_data)
   );

   // A query transaction makes the block busy on the next cycle.
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.opcode == OPC_QUERY |=> req_stall)
      else $error("query accepted but block not busy");

   // A load transaction completes without making the block busy.
   a_load_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.opcode == OPC_LOAD |=> !req_stall)
      else $error("load did not complete in one cycle");

   // A result without a hit carries all-zero fields.
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |->
         rsp_data.distance == '0 && rsp_data.nearest_index == '0 &&
         rsp_data.closest_x == '0 && rsp_data.closest_y == '0)
      else $error("result without a hit has nonzero fields");

endmodule
